// ----- rtl/sas_pkg.sv -----
// Shared definitions for the sprite animation sequencer: operation codes,
// parameter defaults, the result record and a small modulo helper.
// No dependencies.
`timescale 1ns / 1ps

package sas_pkg;

  // Default table sizes.
  localparam int NumActionsDef = 16;
  localparam int MaxFramesDef  = 16;

  // Operation codes carried by the action field of an input transaction.
  localparam logic [1:0] OP_TICK         = 2'd0;
  localparam logic [1:0] OP_CHANGE       = 2'd1;
  localparam logic [1:0] OP_WRITE_FRAME  = 2'd2;
  localparam logic [1:0] OP_WRITE_ACTION = 2'd3;

  // One result record as held in the output queue.
  typedef struct packed {
    logic [7:0] shown_pattern;
    logic [3:0] active_action;
    logic [3:0] active_frame;
    logic       input_allowed;
  } res_t;

  // Reduce a 4-bit action number modulo the table size (at least 2), so at
  // most seven subtractions are ever needed.
  function automatic logic [3:0] mod_action(input logic [3:0] v, input logic [8:0] n);
    logic [8:0] acc;
    acc = {5'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (acc >= n) begin
        acc = acc - n;
      end
    end
    return acc[3:0];
  endfunction

endpackage

// ----- rtl/sprite_animation_sequencer.sv -----
// Sprite animation sequencer top level: frame and action tables, timers and
// the result queue.
// Depends on sas_pkg.
`timescale 1ns / 1ps

// The block takes one transaction per clock cycle unless in_stall is high,
// and returns exactly one result for each, held pending and then queued.
// Each transaction ticks the animation, forces an action change, or
// writes a frame or an action table entry. Both tables sit in memories whose
// read port is addressed by the next value of the current action and frame,
// so the entry for the current frame is already registered when the next
// transaction arrives; a write to that entry is forwarded. Results wait in a
// three-entry queue, and the input is stalled only while that queue together
// with the result being formed would be full. Table entries must be written
// before an animation reaches them.
module sprite_animation_sequencer
  import sas_pkg::*;
#(
  parameter int NUM_ACTIONS = NumActionsDef,
  parameter int MAX_FRAMES  = MaxFramesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_action_index,
  input  logic [3:0]  in_frame_index,
  input  logic [7:0]  in_pattern_index,
  input  logic [7:0]  in_duration,
  input  logic [4:0]  in_frame_count,
  input  logic [3:0]  in_next_action,
  input  logic [15:0] in_stiff_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_shown_pattern,
  output logic [3:0]  out_active_action,
  output logic [3:0]  out_active_frame,
  output logic        out_input_allowed
);

  localparam int SLOTS  = NUM_ACTIONS * MAX_FRAMES;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int AIDX_W = $clog2(NUM_ACTIONS);
  localparam int QDEPTH = 3;

  // Animation state.
  logic [3:0]  cur_action_r, cur_action_nxt;
  logic [3:0]  cur_frame_r, cur_frame_nxt;
  logic [7:0]  frame_timer_r, frame_timer_nxt;
  logic [15:0] action_timer_r, action_timer_nxt;

  // Table memories and their registered read data.
  logic [15:0] frame_store_r [SLOTS];
  logic [24:0] action_store_r [NUM_ACTIONS];
  logic [15:0] frame_word_r;
  logic [24:0] action_word_r;

  // Result queue.
  res_t        queue_r [QDEPTH];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [1:0]  occ_r;
  logic        pend_r;

  logic        in_fire, out_fire;
  logic [2:0]  load;
  logic        action_ok, frame_ok;
  logic        fw_en, aw_en;
  logic [SLOT_W-1:0] fw_addr, fr_addr;
  logic [AIDX_W-1:0] aw_addr, ar_addr;
  logic [AIDX_W+3:0] aw_wide, ar_wide;
  logic [15:0] fw_data;
  logic [24:0] aw_data;
  logic [7:0]  ft_inc;
  logic [8:0]  eff_count, frame_plus;
  logic [4:0]  cnt_field;
  logic        frame_done, action_done;
  res_t        result;

  // Handshakes: stall while the queue plus the pending result could overflow.
  assign load     = {1'b0, occ_r} + {2'b00, pend_r};
  assign in_stall = (load > 3'(QDEPTH - 1));
  assign in_fire  = in_valid && !in_stall;
  assign out_valid = (occ_r != 2'd0);
  assign out_fire  = out_valid && !out_stall;

  // Range checks on the target of a change or a table write.
  assign action_ok = ({5'd0, in_action_index} < 9'(NUM_ACTIONS));
  assign frame_ok  = ({5'd0, in_frame_index} < 9'(MAX_FRAMES));

  // Table write requests.
  assign fw_en   = in_fire && (in_action == OP_WRITE_FRAME) && action_ok && frame_ok;
  assign aw_en   = in_fire && (in_action == OP_WRITE_ACTION) && action_ok;
  assign fw_addr = SLOT_W'(in_action_index) * SLOT_W'(MAX_FRAMES) + SLOT_W'(in_frame_index);
  assign aw_wide = {{AIDX_W{1'b0}}, in_action_index};
  assign aw_addr = aw_wide[AIDX_W-1:0];
  assign fw_data = {in_duration, in_pattern_index};
  assign aw_data = {in_stiff_time, in_next_action, in_frame_count};

  // Frame end and action end decisions for a tick.
  assign ft_inc     = frame_timer_r + 8'd1;
  assign frame_done = (ft_inc == frame_word_r[15:8]);
  assign cnt_field  = action_word_r[4:0];
  assign frame_plus = {5'd0, cur_frame_r} + 9'd1;

  always_comb begin
    eff_count = (cnt_field == 5'd0) ? 9'd1 : {4'd0, cnt_field};
    if (eff_count > 9'(MAX_FRAMES)) begin
      eff_count = 9'(MAX_FRAMES);
    end
  end

  assign action_done = (frame_plus >= eff_count);

  // Next animation state.
  always_comb begin
    cur_action_nxt   = cur_action_r;
    cur_frame_nxt    = cur_frame_r;
    frame_timer_nxt  = frame_timer_r;
    action_timer_nxt = action_timer_r;
    if (in_fire) begin
      case (in_action)
        OP_TICK: begin
          if (action_timer_r != 16'hFFFF) begin
            action_timer_nxt = action_timer_r + 16'd1;
          end
          frame_timer_nxt = ft_inc;
          if (frame_done) begin
            frame_timer_nxt = 8'd0;
            if (action_done) begin
              cur_action_nxt   = mod_action(action_word_r[8:5], 9'(NUM_ACTIONS));
              cur_frame_nxt    = 4'd0;
              action_timer_nxt = 16'd0;
            end else begin
              cur_frame_nxt = cur_frame_r + 4'd1;
            end
          end
        end
        OP_CHANGE: begin
          if (action_ok) begin
            cur_action_nxt   = in_action_index;
            cur_frame_nxt    = 4'd0;
            frame_timer_nxt  = 8'd0;
            action_timer_nxt = 16'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Read addresses follow the next state, so the read data matches the state.
  assign fr_addr = SLOT_W'(cur_action_nxt) * SLOT_W'(MAX_FRAMES) + SLOT_W'(cur_frame_nxt);
  assign ar_wide = {{AIDX_W{1'b0}}, cur_action_nxt};
  assign ar_addr = ar_wide[AIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_action_r   <= 4'd0;
      cur_frame_r    <= 4'd0;
      frame_timer_r  <= 8'd0;
      action_timer_r <= 16'd0;
    end else begin
      cur_action_r   <= cur_action_nxt;
      cur_frame_r    <= cur_frame_nxt;
      frame_timer_r  <= frame_timer_nxt;
      action_timer_r <= action_timer_nxt;
    end
  end

  // Frame table: one write and one registered read, with write forwarding.
  always_ff @(posedge clk) begin
    if (fw_en) begin
      frame_store_r[fw_addr] <= fw_data;
    end
    if (fw_en && (fw_addr == fr_addr)) begin
      frame_word_r <= fw_data;
    end else begin
      frame_word_r <= frame_store_r[fr_addr];
    end
  end

  // Action table: same arrangement.
  always_ff @(posedge clk) begin
    if (aw_en) begin
      action_store_r[aw_addr] <= aw_data;
    end
    if (aw_en && (aw_addr == ar_addr)) begin
      action_word_r <= aw_data;
    end else begin
      action_word_r <= action_store_r[ar_addr];
    end
  end

  // The result of the transaction taken last cycle, formed from the state.
  always_comb begin
    result.shown_pattern = frame_word_r[7:0];
    result.active_action = cur_action_r;
    result.active_frame  = cur_frame_r;
    result.input_allowed = (action_timer_r >= action_word_r[24:9]);
  end

  // Result queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      occ_r    <= 2'd0;
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
    end else begin
      pend_r <= in_fire;
      occ_r  <= occ_r + {1'b0, pend_r} - {1'b0, out_fire};
      if (pend_r) begin
        wr_ptr_r <= (wr_ptr_r == 2'(QDEPTH - 1)) ? 2'd0 : wr_ptr_r + 2'd1;
      end
      if (out_fire) begin
        rd_ptr_r <= (rd_ptr_r == 2'(QDEPTH - 1)) ? 2'd0 : rd_ptr_r + 2'd1;
      end
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (pend_r) begin
      queue_r[wr_ptr_r] <= result;
    end
  end

  assign out_shown_pattern = queue_r[rd_ptr_r].shown_pattern;
  assign out_active_action = queue_r[rd_ptr_r].active_action;
  assign out_active_frame  = queue_r[rd_ptr_r].active_frame;
  assign out_input_allowed = queue_r[rd_ptr_r].input_allowed;

endmodule

// ----- rtl/sas_checker.sv -----
// Port-level checks for the sprite animation sequencer, attached by bind.
// Depends on the sprite_animation_sequencer port list.
`timescale 1ns / 1ps

module sas_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_shown_pattern,
  input logic [3:0]  out_active_action,
  input logic [3:0]  out_active_frame,
  input logic        out_input_allowed
);

  // A stalled result stays offered.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_shown_pattern) && $stable(out_active_action)
      && $stable(out_active_frame) && $stable(out_input_allowed)))
    else $error("result payload changed while stalled");

  // With no result waiting the input must never be stalled.
  a_no_idle_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result queue");

  // A transaction taken while nothing waits shows its result once queued.
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> ##1 out_valid)
    else $error("result missing after an accepted transaction");

endmodule

bind sprite_animation_sequencer sas_port_checks u_sas_port_checks (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_shown_pattern (out_shown_pattern),
  .out_active_action (out_active_action),
  .out_active_frame  (out_active_frame),
  .out_input_allowed (out_input_allowed)
);

// ----- bench/sas_checker.sv -----
// Checker for the sprite animation sequencer: watches both channels, keeps
// its own copy of the tables and timers, and compares every result in order.
// Depends on sas_pkg.
`timescale 1ns / 1ps

module sas_checker
  import sas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_action_index,
  input  logic [3:0]  in_frame_index,
  input  logic [7:0]  in_pattern_index,
  input  logic [7:0]  in_duration,
  input  logic [4:0]  in_frame_count,
  input  logic [3:0]  in_next_action,
  input  logic [15:0] in_stiff_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_shown_pattern,
  input  logic [3:0]  out_active_action,
  input  logic [3:0]  out_active_frame,
  input  logic        out_input_allowed,
  output int          mismatch_count,
  output int          pending_count,
  output int          checked_count,
  output int          chain_count
);

  localparam int ActionSlots = NumActionsDef;
  localparam int FrameSlots  = MaxFramesDef;
  localparam int MaxReports  = 40;

  typedef struct packed {
    logic [7:0] pattern;
    logic [7:0] duration;
  } frame_entry_t;

  typedef struct packed {
    logic [4:0]  count;
    logic [3:0]  next_act;
    logic [15:0] stiff;
  } action_entry_t;

  // A predicted result, with flags for fields that come from table entries
  // the block has not been given yet.
  typedef struct {
    res_t view;
    bit   pattern_known;
    bit   allow_known;
  } sprite_view_t;

  frame_entry_t  frame_tbl      [ActionSlots * FrameSlots];
  action_entry_t action_tbl     [ActionSlots];
  bit            frame_written  [ActionSlots * FrameSlots];
  bit            action_written [ActionSlots];
  logic [3:0]    cur_act;
  logic [3:0]    cur_frm;
  logic [7:0]    frm_timer;
  logic [15:0]   act_timer;
  sprite_view_t  predicted_views [$];

  function automatic int slot_of(input logic [3:0] act, input logic [3:0] frm);
    return int'(act) * FrameSlots + int'(frm);
  endfunction

  // Entering an action clears the frame and both timers.
  task automatic restart_action(input logic [3:0] act);
    cur_act   = 4'(act % ActionSlots);
    cur_frm   = '0;
    frm_timer = '0;
    act_timer = '0;
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxReports) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Apply one accepted transaction to the local state and queue the view
  // that the block should return for it.
  task automatic advance_animation();
    action_entry_t aw;
    frame_entry_t  fw;
    sprite_view_t  v;
    int            frames;
    int            s;
    case (in_action)
      OP_TICK: begin
        aw = action_tbl[cur_act];
        fw = frame_tbl[slot_of(cur_act, cur_frm)];
        if (act_timer != 16'hFFFF) begin
          act_timer = act_timer + 16'd1;
        end
        frm_timer = frm_timer + 8'd1;
        if (frm_timer == fw.duration) begin
          frm_timer = '0;
          // A count of zero still plays one frame; large counts are clipped.
          frames = (aw.count == 5'd0) ? 1 :
                   ((aw.count > FrameSlots) ? FrameSlots : int'(aw.count));
          if (int'(cur_frm) + 1 >= frames) begin
            restart_action(aw.next_act);
            chain_count++;
          end else begin
            cur_frm = cur_frm + 4'd1;
          end
        end
      end
      OP_CHANGE: begin
        if (in_action_index < ActionSlots) begin
          restart_action(in_action_index);
        end
      end
      OP_WRITE_FRAME: begin
        if (in_action_index < ActionSlots && in_frame_index < FrameSlots) begin
          s = slot_of(in_action_index, in_frame_index);
          frame_tbl[s].pattern  = in_pattern_index;
          frame_tbl[s].duration = in_duration;
          frame_written[s]      = 1'b1;
        end
      end
      default: begin
        if (in_action_index < ActionSlots) begin
          action_tbl[in_action_index].count    = in_frame_count;
          action_tbl[in_action_index].next_act = in_next_action;
          action_tbl[in_action_index].stiff    = in_stiff_time;
          action_written[in_action_index]      = 1'b1;
        end
      end
    endcase

    s = slot_of(cur_act, cur_frm);
    v.view.shown_pattern = frame_tbl[s].pattern;
    v.view.active_action = cur_act;
    v.view.active_frame  = cur_frm;
    v.view.input_allowed = (act_timer >= action_tbl[cur_act].stiff);
    v.pattern_known      = frame_written[s];
    v.allow_known        = action_written[cur_act];
    predicted_views.insert(predicted_views.size(), v);
  endtask

  // Predict on input transactions first, then check the oldest prediction
  // against any result transaction at the same edge.
  always @(posedge clk) begin
    sprite_view_t want;
    if (!rst_n) begin
      cur_act   = '0;
      cur_frm   = '0;
      frm_timer = '0;
      act_timer = '0;
      foreach (frame_written[i]) frame_written[i] = 1'b0;
      foreach (action_written[i]) action_written[i] = 1'b0;
      predicted_views.delete();
    end else begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        advance_animation();
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (predicted_views.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          want = predicted_views.pop_front();
          checked_count++;
          if (want.pattern_known && out_shown_pattern !== want.view.shown_pattern) begin
            report_mismatch($sformatf("shown_pattern %h, predicted %h",
                                      out_shown_pattern, want.view.shown_pattern));
          end
          if (out_active_action !== want.view.active_action) begin
            report_mismatch($sformatf("active_action %h, predicted %h",
                                      out_active_action, want.view.active_action));
          end
          if (out_active_frame !== want.view.active_frame) begin
            report_mismatch($sformatf("active_frame %h, predicted %h",
                                      out_active_frame, want.view.active_frame));
          end
          if (want.allow_known && out_input_allowed !== want.view.input_allowed) begin
            report_mismatch($sformatf("input_allowed %b, predicted %b",
                                      out_input_allowed, want.view.input_allowed));
          end
        end
      end
    end
    pending_count = predicted_views.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top level of the sprite animation sequencer bench: clock, reset, stimulus
// and the final verdict; results are checked by sas_checker.
// Depends on sas_pkg, sprite_animation_sequencer and sas_checker.
`timescale 1ns / 1ps

module testbench
  import sas_pkg::*;
();

  localparam int RandomItems = 950;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 10;

  // One input transaction as the sender sees it.
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  act_idx;
    logic [3:0]  frm_idx;
    logic [7:0]  pattern;
    logic [7:0]  duration;
    logic [4:0]  count;
    logic [3:0]  next_act;
    logic [15:0] stiff;
  } sprite_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [3:0]  in_action_index;
  logic [3:0]  in_frame_index;
  logic [7:0]  in_pattern_index;
  logic [7:0]  in_duration;
  logic [4:0]  in_frame_count;
  logic [3:0]  in_next_action;
  logic [15:0] in_stiff_time;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_shown_pattern;
  logic [3:0]  out_active_action;
  logic [3:0]  out_active_frame;
  logic        out_input_allowed;
  int          mismatch_count;
  int          pending_count;
  int          checked_count;
  int          chain_count;
  int          sent_count = 0;
  bit          hold_req;
  bit          quiet;

  sprite_animation_sequencer uut (.*);
  sas_checker u_checker (.*);

  always #5 clk = ~clk;

  function automatic sprite_cmd_t cmd_of(input logic [1:0] op, input logic [3:0] ai,
                                         input logic [3:0] fi, input logic [7:0] pat,
                                         input logic [7:0] dur, input logic [4:0] cnt,
                                         input logic [3:0] nxt, input logic [15:0] stf);
    sprite_cmd_t c;
    c = '{op, ai, fi, pat, dur, cnt, nxt, stf};
    return c;
  endfunction

  // Mostly short frames so that animations move, with both extremes mixed in.
  function automatic logic [7:0] rand_duration();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 8'($urandom_range(1, 4));
    if (p < 80) return 8'd0;
    if (p < 88) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic logic [4:0] rand_count();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 5'($urandom_range(1, 4));
    if (p < 70) return 5'd0;
    if (p < 80) return 5'd16;
    if (p < 90) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(5, 15));
  endfunction

  function automatic logic [15:0] rand_stiff();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 16'($urandom_range(0, 15));
    if (p < 75) return 16'd0;
    if (p < 85) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Offer one transaction after a random gap and hold it until accepted.
  // Called and returns at a falling edge.
  task automatic send_cmd(input sprite_cmd_t c);
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= c.op;
    in_action_index  <= c.act_idx;
    in_frame_index   <= c.frm_idx;
    in_pattern_index <= c.pattern;
    in_duration      <= c.duration;
    in_frame_count   <= c.count;
    in_next_action   <= c.next_act;
    in_stiff_time    <= c.stiff;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_cmd(cmd_of(OP_TICK, 4'd0, 4'd0, 8'd0, 8'd0, 5'd0, 4'd0, 16'd0));
  endtask

  // Result side: random stalls, plus long hold-offs on request so the block
  // fills up and stalls its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !quiet && ($urandom_range(99) < 26);
    end
  end

  // Stimulus and verdict.
  initial begin
    sprite_cmd_t c;
    logic [63:0] raw;
    int          pick;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_action        = OP_TICK;
    in_action_index  = '0;
    in_frame_index   = '0;
    in_pattern_index = '0;
    in_duration      = '0;
    in_frame_count   = '0;
    in_next_action   = '0;
    in_stiff_time    = '0;
    hold_req         = 1'b0;
    quiet            = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill both tables before any tick, starting with the entries that the
    // current action reads straight out of reset.
    send_cmd(cmd_of(OP_WRITE_ACTION, 4'd0, 4'd0, 8'd0, 8'd0, rand_count(),
                    4'($urandom), rand_stiff()));
    for (int a = 0; a < NumActionsDef; a++) begin
      for (int f = 0; f < MaxFramesDef; f++) begin
        send_cmd(cmd_of(OP_WRITE_FRAME, 4'(a), 4'(f), 8'($urandom), rand_duration(),
                        5'd0, 4'd0, 16'd0));
      end
    end
    for (int a = 1; a < NumActionsDef; a++) begin
      send_cmd(cmd_of(OP_WRITE_ACTION, 4'(a), 4'd0, 8'd0, 8'd0, rand_count(),
                      4'($urandom), rand_stiff()));
    end

    // A zero frame count plays one frame and chains at once into a clipped
    // sixteen-frame action.
    send_cmd(cmd_of(OP_WRITE_ACTION, 4'd2, 4'd0, 8'd0, 8'd0, 5'd0, 4'd15, 16'hFFFF));
    send_cmd(cmd_of(OP_WRITE_FRAME, 4'd2, 4'd0, 8'hFF, 8'd1, 5'd0, 4'd0, 16'd0));
    send_cmd(cmd_of(OP_WRITE_ACTION, 4'd15, 4'd0, 8'd0, 8'd0, 5'd31, 4'd0, 16'd0));
    send_cmd(cmd_of(OP_WRITE_FRAME, 4'd15, 4'd0, 8'h00, 8'd2, 5'd0, 4'd0, 16'd0));
    send_cmd(cmd_of(OP_CHANGE, 4'd2, 4'd0, 8'd0, 8'd0, 5'd0, 4'd0, 16'd0));
    send_ticks(3);

    // An action shortened while it runs ends at its next frame boundary.
    send_cmd(cmd_of(OP_WRITE_ACTION, 4'd3, 4'd0, 8'd0, 8'd0, 5'd4, 4'd1, 16'd3));
    for (int f = 0; f < 4; f++) begin
      send_cmd(cmd_of(OP_WRITE_FRAME, 4'd3, 4'(f), 8'(8'h30 + f), 8'd1, 5'd0, 4'd0, 16'd0));
    end
    send_cmd(cmd_of(OP_WRITE_ACTION, 4'd1, 4'd0, 8'd0, 8'd0, 5'd1, 4'd2, 16'd2));
    send_cmd(cmd_of(OP_WRITE_FRAME, 4'd1, 4'd0, 8'h80, 8'd0, 5'd0, 4'd0, 16'd0));
    send_cmd(cmd_of(OP_CHANGE, 4'd3, 4'd0, 8'd0, 8'd0, 5'd0, 4'd0, 16'd0));
    send_ticks(2);
    send_cmd(cmd_of(OP_WRITE_ACTION, 4'd3, 4'd0, 8'd0, 8'd0, 5'd1, 4'd1, 16'd3));
    send_ticks(1);

    // A zero duration lasts a full wrap of the frame timer.
    send_ticks(257);
    send_cmd(cmd_of(OP_CHANGE, 4'd0, 4'd0, 8'd0, 8'd0, 5'd0, 4'd0, 16'd0));

    // Random traffic: mostly ticks, with changes and table rewrites mixed in.
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 200 || n == 900) hold_req = 1'b1;
      quiet = (n >= 500 && n < 800);
      raw = {$urandom, $urandom};
      c = raw[$bits(sprite_cmd_t)-1:0];
      pick = $urandom_range(99);
      if (pick < 60) begin
        c.op = OP_TICK;
      end else if (pick < 70) begin
        c.op = OP_CHANGE;
      end else if (pick < 85) begin
        c.op = OP_WRITE_FRAME;
        if ($urandom_range(3) != 0) c.duration = rand_duration();
      end else begin
        c.op = OP_WRITE_ACTION;
        if ($urandom_range(3) != 0) begin
          c.count = rand_count();
          c.stiff = rand_stiff();
        end
      end
      send_cmd(c);
    end
    quiet = 1'b0;

    // Drain the outstanding results, then wait out DrainCycles for strays.
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    $display("Covered table loads, chained and shortened actions, a full frame timer wrap");
    $display("and back-pressure: %0d transactions sent, %0d results checked, %0d chains.",
             sent_count, checked_count, chain_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
